>>> sv/fce_pkg.sv
package fce_pkg;

    // Default table depth.
    localparam int FAT_ENTRIES_DEF = 2048;

    // Link value that ends a chain.
    localparam logic [15:0] END_MARK = 16'hFFFF;

    // Operation codes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_EXTEND = 2'd2;
    localparam logic [1:0] OP_FREE   = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BEYOND  = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;

endpackage

>>> sv/fat_chain_engine_top.sv
// Load writes one entry; find follows the chain from its head to block number n; free clears
// each entry of a chain of k blocks while following its link. Extend walks to the tail, then a
// first-fit scan finds a new head for an empty chain and each further block and links it on.
// One operation at a time; busy is high while a walk or scan is under way and falls as the result beat appears.
// Reset: the table is cleared one entry a cycle with busy high.
// Each result beat is on the ports for one cycle under done; the receiver cannot stall.
module fat_chain_engine_top
    import fce_pkg::*;
#(
    parameter int FAT_ENTRIES = FAT_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] chain_head,
    input  logic [10:0] block_count,
    input  logic [10:0] entry_index,
    input  logic [15:0] entry_value,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] found_block,
    output logic [15:0] new_head
);

    localparam int AW   = $clog2(FAT_ENTRIES);
    localparam int LW   = AW + 2;
    localparam int CMPW = (LW > 11) ? LW : 11;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FIND  = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_GROW  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_LINK  = 4'd6;
    localparam logic [3:0] S_FREE  = 4'd7;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_ptr_reg, clr_ptr_next;
    logic [15:0]   head_reg, head_next;
    logic [10:0]   count_reg, count_next;
    logic [10:0]   cnt_reg, cnt_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] free_reg, free_next;
    logic [LW-1:0] len_reg, len_next;
    logic [AW:0]   steps_reg, steps_next;
    logic [AW:0]   cursor_reg, cursor_next;
    logic [AW:0]   scan_ptr_reg, scan_ptr_next;
    logic [AW-1:0] chk_ptr_reg, chk_ptr_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          scan_head_reg, scan_head_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   blk_reg, blk_next;
    logic [15:0]   nhead_reg, nhead_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic          accept;
    logic          head_ok;
    logic          rdata_ok;

    function automatic logic link_ok(input logic [15:0] v);
        return (v != 16'd0) && ({1'b0, v} < 17'(FAT_ENTRIES));
    endfunction

    fce_ram #(
        .WIDTH (16),
        .DEPTH (FAT_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign head_ok  = link_ok(chain_head);
    assign rdata_ok = link_ok(ram_rdata);

    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        tail_next      = tail_reg;
        idx_next       = idx_reg;
        free_next      = free_reg;
        len_next       = len_reg;
        steps_next     = steps_reg;
        cursor_next    = cursor_reg;
        scan_ptr_next  = scan_ptr_reg;
        chk_ptr_next   = chk_ptr_reg;
        rd_vld_next    = 1'b0;
        scan_head_next = scan_head_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        blk_next       = blk_reg;
        nhead_next     = nhead_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = 16'd0;
        ram_raddr      = idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == AW'(FAT_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    head_next  = chain_head;
                    count_next = block_count;
                    case (op)
                        OP_LOAD:
                        begin
                            ram_we      = (int'(entry_index) < FAT_ENTRIES);
                            ram_waddr   = AW'(entry_index);
                            ram_wdata   = entry_value;
                            done_next   = 1'b1;
                            status_next = STAT_OK;
                            blk_next    = 16'd0;
                            nhead_next  = chain_head;
                        end
                        OP_FIND:
                        begin
                            ram_raddr = AW'(chain_head);
                            cnt_next  = block_count;
                            if (!head_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_BEYOND;
                                blk_next    = END_MARK;
                                nhead_next  = chain_head;
                            end
                            else if (block_count == 11'd0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_OK;
                                blk_next    = chain_head;
                                nhead_next  = chain_head;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        OP_EXTEND:
                        begin
                            ram_raddr   = AW'(chain_head);
                            tail_next   = AW'(chain_head);
                            len_next    = LW'(1);
                            steps_next  = (AW+1)'(1);
                            cursor_next = (AW+1)'(1);
                            if (head_ok)
                            begin
                                scan_head_next = 1'b0;
                                state_next     = S_WALK;
                            end
                            else
                            begin
                                scan_head_next = 1'b1;
                                scan_ptr_next  = (AW+1)'(1);
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            ram_raddr = AW'(chain_head);
                            idx_next  = AW'(chain_head);
                            if (head_ok)
                            begin
                                state_next = S_FREE;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_OK;
                                blk_next    = 16'd0;
                                nhead_next  = END_MARK;
                            end
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                // The next link is read while this one is checked.
                ram_raddr = AW'(ram_rdata);
                cnt_next  = cnt_reg - 1'b1;
                if (!rdata_ok)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_BEYOND;
                    blk_next    = END_MARK;
                    nhead_next  = head_reg;
                    state_next  = S_IDLE;
                end
                else if (cnt_reg == 11'd1)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    blk_next    = ram_rdata;
                    nhead_next  = head_reg;
                    state_next  = S_IDLE;
                end
            end
            S_WALK:
            begin
                ram_raddr = AW'(ram_rdata);
                if (rdata_ok && (steps_reg < (AW+1)'(FAT_ENTRIES)))
                begin
                    tail_next  = AW'(ram_rdata);
                    len_next   = len_reg + 1'b1;
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end
            S_GROW:
            begin
                if (CMPW'(len_reg) < CMPW'(count_reg))
                begin
                    scan_ptr_next = cursor_reg;
                    state_next    = S_SCAN;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    blk_next    = 16'(tail_reg);
                    nhead_next  = head_reg;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // One entry is read per cycle; its contents are checked in the next.
                ram_raddr = AW'(scan_ptr_reg);
                if (rd_vld_reg && (ram_rdata == 16'd0))
                begin
                    ram_we = 1'b1;
                    if (scan_head_reg)
                    begin
                        ram_waddr      = chk_ptr_reg;
                        ram_wdata      = END_MARK;
                        head_next      = 16'(chk_ptr_reg);
                        tail_next      = chk_ptr_reg;
                        cursor_next    = (AW+1)'(chk_ptr_reg) + 1'b1;
                        len_next       = LW'(1);
                        scan_head_next = 1'b0;
                        state_next     = S_GROW;
                    end
                    else
                    begin
                        ram_waddr  = tail_reg;
                        ram_wdata  = 16'(chk_ptr_reg);
                        free_next  = chk_ptr_reg;
                        state_next = S_LINK;
                    end
                end
                else if (scan_ptr_reg < (AW+1)'(FAT_ENTRIES))
                begin
                    chk_ptr_next  = AW'(scan_ptr_reg);
                    rd_vld_next   = 1'b1;
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOSPACE;
                    blk_next    = scan_head_reg ? END_MARK : 16'(tail_reg);
                    nhead_next  = scan_head_reg ? END_MARK : head_reg;
                    state_next  = S_IDLE;
                end
            end
            S_LINK:
            begin
                ram_we      = 1'b1;
                ram_waddr   = free_reg;
                ram_wdata   = END_MARK;
                tail_next   = free_reg;
                cursor_next = (AW+1)'(free_reg) + 1'b1;
                len_next    = len_reg + 1'b1;
                state_next  = S_GROW;
            end
            S_FREE:
            begin
                // Clear this entry while its link is followed.
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = 16'd0;
                ram_raddr = AW'(ram_rdata);
                if (rdata_ok)
                begin
                    idx_next = AW'(ram_rdata);
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    blk_next    = 16'd0;
                    nhead_next  = END_MARK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_ptr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            rd_vld_reg  <= rd_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        count_reg     <= count_next;
        cnt_reg       <= cnt_next;
        tail_reg      <= tail_next;
        idx_reg       <= idx_next;
        free_reg      <= free_next;
        len_reg       <= len_next;
        steps_reg     <= steps_next;
        cursor_reg    <= cursor_next;
        scan_ptr_reg  <= scan_ptr_next;
        chk_ptr_reg   <= chk_ptr_next;
        scan_head_reg <= scan_head_next;
        status_reg    <= status_next;
        blk_reg       <= blk_next;
        nhead_reg     <= nhead_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_block = blk_reg;
    assign new_head    = nhead_reg;

`ifndef SYNTH
    // A result beat follows either an accept or a cycle of work.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a preceding operation");

    // The clearing pass never produces a result.
    a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done)
        else $error("result beat during the clearing pass");

    // A find only reads the table.
    a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) |-> !ram_we)
        else $error("table written during find");

    // Running out of space can only come from a failed free-entry scan.
    a_nospace_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_NOSPACE)) |-> $past(state_reg == S_SCAN))
        else $error("no-space status outside a scan");

    // A successful find never reports the end mark.
    a_find_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(state_reg == S_FIND) && (status == STAT_OK))
            |-> (found_block != END_MARK))
        else $error("find reported the end mark as a block");
`endif

endmodule

>>> sv/fce_ram.sv
module fce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> bench/fat_chain_checker.sv
module fat_chain_checker
    import fce_pkg::*;
#(
    parameter int FAT_ENTRIES = FAT_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] chain_head,
    input  logic [10:0] block_count,
    input  logic [10:0] entry_index,
    input  logic [15:0] entry_value,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [15:0] found_block,
    input  logic [15:0] new_head,
    output int          fail_count,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] chain_head;
        logic [10:0] block_count;
        logic [10:0] entry_index;
        logic [15:0] entry_value;
    } chain_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_block;
        logic [15:0] new_head;
    } chain_res_t;

    logic [15:0] link_tab [FAT_ENTRIES];
    chain_res_t  expected_q [$];
    int          mismatch_total = 0;
    int          queued = 0;
    int          beat_no = 0;

    assign fail_count = mismatch_total;
    assign pending    = queued;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic bit valid_link(input int unsigned idx);
        return idx >= 1 && idx < FAT_ENTRIES;
    endfunction

    // First-fit search for a free entry; 0 stands for none, as entry 0 is reserved.
    function automatic int unsigned first_free(input int unsigned from);
        for (int unsigned i = from; i < FAT_ENTRIES; i++) begin
            if (link_tab[i] == 16'h0000)
                return i;
        end
        return 0;
    endfunction

    task automatic run_chain_op(input chain_cmd_t c, output chain_res_t r);
        int unsigned idx, nxt, tail, cur, len, steps, cursor, fr, n;
        bit walk_ok;
        r.status      = STAT_OK;
        r.found_block = 16'h0000;
        r.new_head    = c.chain_head;
        case (c.op)
            OP_LOAD: begin
                if (c.entry_index < FAT_ENTRIES)
                    link_tab[c.entry_index] = c.entry_value;
            end
            OP_FIND: begin
                idx = {16'h0000, c.chain_head};
                walk_ok = valid_link(idx);
                for (n = 0; walk_ok && n < c.block_count; n++) begin
                    idx = {16'h0000, link_tab[idx]};
                    walk_ok = valid_link(idx);
                end
                if (walk_ok) begin
                    r.found_block = idx[15:0];
                end else begin
                    r.status      = STAT_BEYOND;
                    r.found_block = END_MARK;
                end
            end
            OP_EXTEND: begin
                cursor = 1;
                tail   = {16'h0000, c.chain_head};
                fr     = 1;
                // A head that is no valid link means an empty chain, so a head is made first.
                if (!valid_link(tail)) begin
                    fr = first_free(1);
                    if (fr != 0) begin
                        link_tab[fr] = END_MARK;
                        tail   = fr;
                        cursor = fr + 1;
                    end
                end
                if (fr == 0) begin
                    r.status      = STAT_NOSPACE;
                    r.found_block = END_MARK;
                    r.new_head    = END_MARK;
                end else begin
                    r.new_head = tail[15:0];
                    len   = 1;
                    steps = 1;
                    cur   = {16'h0000, link_tab[tail]};
                    // The step bound ends the walk on a cyclic chain.
                    while (valid_link(cur) && steps < FAT_ENTRIES) begin
                        tail = cur;
                        len++;
                        steps++;
                        cur = {16'h0000, link_tab[tail]};
                    end
                    while (len < c.block_count && r.status == STAT_OK) begin
                        fr = first_free(cursor);
                        if (fr == 0) begin
                            r.status = STAT_NOSPACE;
                        end else begin
                            link_tab[tail] = fr[15:0];
                            link_tab[fr]   = END_MARK;
                            tail   = fr;
                            cursor = fr + 1;
                            len++;
                        end
                    end
                    r.found_block = tail[15:0];
                end
            end
            OP_FREE: begin
                idx = {16'h0000, c.chain_head};
                while (valid_link(idx)) begin
                    nxt = {16'h0000, link_tab[idx]};
                    link_tab[idx] = 16'h0000;
                    idx = nxt;
                end
                r.new_head = END_MARK;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        chain_cmd_t cmd;
        chain_res_t want;
        if (!rst_n) begin
            for (int i = 0; i < FAT_ENTRIES; i++)
                link_tab[i] = 16'h0000;
            expected_q.delete();
            queued <= 0;
        end else begin
            // The result beat of the previous operation is checked before a new beat
            // accepted on the same edge is predicted.
            if (done) begin
                beat_no++;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                              beat_no));
                end else begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("beat %0d status got %0d expected %0d",
                                                  beat_no, status, want.status));
                    if (found_block !== want.found_block)
                        report_mismatch($sformatf("beat %0d found_block got %h expected %h",
                                                  beat_no, found_block, want.found_block));
                    if (new_head !== want.new_head)
                        report_mismatch($sformatf("beat %0d new_head got %h expected %h",
                                                  beat_no, new_head, want.new_head));
                end
            end
            if (start && !busy) begin
                cmd = '{op, chain_head, block_count, entry_index, entry_value};
                run_chain_op(cmd, want);
                expected_q.push_back(want);
            end
            queued <= expected_q.size();
        end
    end

endmodule

>>> bench/fat_chain_engine_top_tb.sv
module fat_chain_engine_top_tb;

    import fce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 265;
    localparam int CYCLE_LIMIT  = 16_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = OP_LOAD;
    logic [15:0] chain_head = 16'h0000;
    logic [10:0] block_count = 11'd0;
    logic [10:0] entry_index = 11'd0;
    logic [15:0] entry_value = 16'h0000;
    logic        done;
    logic [1:0]  status;
    logic [15:0] found_block;
    logic [15:0] new_head;

    int          fail_total;
    int          pending_beats;
    int          idle_pct = 17;
    int          cycle_count = 0;
    logic [15:0] last_head = END_MARK;
    logic [15:0] head_pool [8] = '{default: 16'd1};

    fat_chain_engine_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .chain_head  (chain_head),
        .block_count (block_count),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .done        (done),
        .status      (status),
        .found_block (found_block),
        .new_head    (new_head)
    );

    fat_chain_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .chain_head  (chain_head),
        .block_count (block_count),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .done        (done),
        .status      (status),
        .found_block (found_block),
        .new_head    (new_head),
        .fail_count  (fail_total),
        .pending     (pending_beats)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Heads handed back by the block are reused so that most operations hit real chains.
    always @(posedge clk)
    begin
        if (done) begin
            last_head <= new_head;
            if (new_head >= 16'd1 && new_head < FAT_ENTRIES_DEF)
                head_pool[$urandom_range(0, 7)] <= new_head;
        end
    end

    task automatic issue_op(input logic [1:0] o, input logic [15:0] h, input logic [10:0] n,
                            input logic [10:0] ei, input logic [15:0] ev);
        op          <= o;
        chain_head  <= h;
        block_count <= n;
        entry_index <= ei;
        entry_value <= ev;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // The first edge lets the count of outstanding beats catch up with the last accept.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_head();
        int unsigned roll;
        logic [15:0] h;
        roll = $urandom_range(0, 99);
        h = 16'($urandom);
        if (roll < 60)
            h = head_pool[$urandom_range(0, 7)];
        else if (roll < 80)
            h = 16'($urandom_range(1, 60));
        else if (roll < 90)
            h = END_MARK;
        return h;
    endfunction

    initial
    begin
        int unsigned roll;
        logic [1:0]  r_op;
        logic [15:0] r_head;
        logic [10:0] r_count;
        logic [10:0] r_index;
        logic [15:0] r_value;
        logic [15:0] fill_head;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty and invalid heads, ends of chains, broken and cyclic chains,
        // links past the table, running out of space and field extremes.
        issue_op(OP_FIND,   END_MARK,  11'd0,    11'd0,    16'h0000);
        issue_op(OP_EXTEND, END_MARK,  11'd0,    11'd0,    16'h0000);
        issue_op(OP_EXTEND, 16'd1,     11'd6,    11'd0,    16'h0000);
        issue_op(OP_FIND,   16'd1,     11'd0,    11'd0,    16'h0000);
        issue_op(OP_FIND,   16'd1,     11'd5,    11'd0,    16'h0000);
        issue_op(OP_FIND,   16'd1,     11'd6,    11'd0,    16'h0000);
        issue_op(OP_FIND,   16'h0000,  11'd0,    11'd0,    16'h0000);
        issue_op(OP_FIND,   16'h0800,  11'd0,    11'd0,    16'h0000);
        issue_op(OP_EXTEND, 16'h0000,  11'd3,    11'd0,    16'h0000);
        issue_op(OP_LOAD,   16'd0,     11'd0,    11'd3,    16'h0000);
        issue_op(OP_FIND,   16'd1,     11'd4,    11'd0,    16'h0000);
        issue_op(OP_EXTEND, 16'd1,     11'd4,    11'd0,    16'h0000);
        issue_op(OP_LOAD,   16'd0,     11'd0,    11'd40,   16'd41);
        issue_op(OP_LOAD,   16'd0,     11'd0,    11'd41,   16'd40);
        issue_op(OP_EXTEND, 16'd40,    11'd2,    11'd0,    16'h0000);
        issue_op(OP_FIND,   16'd40,    11'd2047, 11'd0,    16'h0000);
        issue_op(OP_FREE,   16'd40,    11'd0,    11'd0,    16'h0000);
        issue_op(OP_LOAD,   16'd0,     11'd0,    11'd2047, 16'hFFFF);
        issue_op(OP_LOAD,   16'd0,     11'd0,    11'd0,    16'h1234);
        issue_op(OP_LOAD,   16'd0,     11'd0,    11'd42,   16'h9000);
        issue_op(OP_FIND,   16'd42,    11'd1,    11'd0,    16'h0000);
        issue_op(OP_EXTEND, END_MARK,  11'd2047, 11'd0,    16'h0000);
        // Wait for the fill result so that its head can be released.
        drain_results();
        fill_head = last_head;
        issue_op(OP_EXTEND, END_MARK,  11'd0,    11'd0,    16'h0000);
        issue_op(OP_FREE,   fill_head, 11'd0,    11'd0,    16'h0000);
        issue_op(OP_FREE,   16'd1,     11'd0,    11'd0,    16'h0000);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 97)
                idle_pct = 55;
            else if (k == 194)
                idle_pct = 0;
            if (k == 150)
                drain_results();

            // Fields an operation does not use still carry random values.
            r_head  = pick_head();
            r_count = 11'($urandom);
            r_index = 11'($urandom);
            r_value = 16'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                r_op = OP_LOAD;
                if ($urandom_range(0, 1) == 0)
                    r_index = 11'($urandom_range(1, 64));
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    r_value = 16'h0000;
                else if (roll < 60)
                    r_value = END_MARK;
                else if (roll < 85)
                    r_value = 16'($urandom_range(1, 64));
            end else if (roll < 45) begin
                r_op = OP_FIND;
                if ($urandom_range(0, 99) < 85)
                    r_count = 11'($urandom_range(0, 10));
            end else if (roll < 75) begin
                r_op = OP_EXTEND;
                roll = $urandom_range(0, 99);
                if (roll < 90)
                    r_count = 11'($urandom_range(0, 12));
                else if (roll < 97)
                    r_count = 11'($urandom_range(13, 200));
            end else begin
                r_op = OP_FREE;
            end
            issue_op(r_op, r_head, r_count, r_index, r_value);
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (fail_total == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
